// ===== sv/bdl_pkg.sv =====
// ----------------------------------------------------------------------------
// bdl_pkg: shared constants for the button debouncer
// Register indexes, reset values, field widths and the calibrate button map.
// ----------------------------------------------------------------------------
`default_nettype none

package bdl_pkg;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = CFG_IDX_W'(1);

    localparam int unsigned DEBOUNCE_W   = 16;
    localparam int unsigned LONG_PRESS_W = 32;

    localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_RESET   = DEBOUNCE_W'(50);
    localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RESET = LONG_PRESS_W'(5000);

    // calibrate slots: slot 0 is current (button 3), slot 1 is voltage (button 2)
    localparam int unsigned NUM_CAL = 2;
    localparam int unsigned CAL_CURRENT_BTN = 3;
    localparam int unsigned CAL_VOLTAGE_BTN = 2;
    localparam int unsigned CAL_BTN [NUM_CAL] = '{CAL_CURRENT_BTN, CAL_VOLTAGE_BTN};

endpackage

`default_nettype wire

// ===== sv/bdl_if.sv =====
// ----------------------------------------------------------------------------
// bdl_if: handshake channels of the debouncer
// A generic valid/ready stream and the configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdl_stream_if #(
    parameter int unsigned WIDTH = 8
) ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bdl_cfg_if ();
    import bdl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/bdl_lane.sv =====
// ----------------------------------------------------------------------------
// bdl_lane: debounce core for one button
// Tracks the last raw level and its change time; promotes the raw level to
// the debounced level once it has held longer than the debounce time.
// ----------------------------------------------------------------------------
`default_nettype none

module bdl_lane #(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire                              i_raw,
    input  wire [TIME_BITS-1:0]              i_now,
    input  wire [bdl_pkg::DEBOUNCE_W-1:0]    i_debounce_ms,
    output logic                             o_level,
    output logic                             o_prev
);
    import bdl_pkg::*;

    localparam int unsigned CMP_W = (TIME_BITS > DEBOUNCE_W) ? TIME_BITS : DEBOUNCE_W;

    logic                 r_last_raw;
    logic [TIME_BITS-1:0] r_change_time;
    logic                 r_level;
    logic                 r_prev;

    logic                 w_changed;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_settled;

    // a fresh change never settles: the compare is gated off in the scan that changes
    assign w_changed = (i_raw != r_last_raw);
    assign w_elapsed = i_now - r_change_time;
    assign w_settled = !w_changed && (CMP_W'(w_elapsed) > CMP_W'(i_debounce_ms));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b1;
            r_change_time <= '0;
            r_level       <= 1'b0;
            r_prev        <= 1'b0;
        end else if (i_en) begin
            r_last_raw <= i_raw;
            if (w_changed) begin
                r_change_time <= i_now;
            end
            if (w_settled) begin
                r_prev  <= r_level;
                r_level <= i_raw;
            end
        end
    end

    assign o_level = r_level;
    assign o_prev  = r_prev;

endmodule

`default_nettype wire

// ===== sv/bdl_merge.sv =====
// ----------------------------------------------------------------------------
// bdl_merge: combines lane levels and runs long-press detection
// Captures the debounced levels into the result register and keeps the
// press times and sticky calibrate flags of the two calibrate buttons.
// ----------------------------------------------------------------------------
`default_nettype none

module bdl_merge #(
    parameter int unsigned NUM_BUTTONS = 4,
    parameter int unsigned TIME_BITS   = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_advance,
    input  wire [TIME_BITS-1:0]                i_now,
    input  wire [NUM_BUTTONS-1:0]              i_levels,
    input  wire [NUM_BUTTONS-1:0]              i_prevs,
    input  wire [bdl_pkg::LONG_PRESS_W-1:0]    i_long_press_ms,
    output logic [NUM_BUTTONS-1:0]             o_levels,
    output logic [NUM_BUTTONS-1:0]             o_prevs,
    output logic [bdl_pkg::NUM_CAL-1:0]        o_cal_flags
);
    import bdl_pkg::*;

    localparam int unsigned CMP_W = (TIME_BITS > LONG_PRESS_W) ? TIME_BITS : LONG_PRESS_W;

    logic [NUM_BUTTONS-1:0] r_levels;
    logic [NUM_BUTTONS-1:0] r_prevs;

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_levels <= i_levels;
            r_prevs  <= i_prevs;
        end
    end

    assign o_levels = r_levels;
    assign o_prevs  = r_prevs;

    for (genvar s = 0; s < NUM_CAL; s++) begin : g_cal
        if (CAL_BTN[s] < NUM_BUTTONS) begin : g_on
            localparam int unsigned BTN = CAL_BTN[s];

            logic [TIME_BITS-1:0] r_press_time;
            logic                 r_flag;
            logic                 w_fall;
            logic [TIME_BITS-1:0] w_held;
            logic                 w_long;

            // no long press is seen on the falling edge itself: the compare is gated off there
            assign w_fall = i_prevs[BTN] && !i_levels[BTN];
            assign w_held = i_now - r_press_time;
            assign w_long = !i_levels[BTN] && !w_fall &&
                            (CMP_W'(w_held) > CMP_W'(i_long_press_ms));

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_press_time <= '0;
                    r_flag       <= 1'b0;
                end else if (i_advance) begin
                    if (w_fall) begin
                        r_press_time <= i_now;
                    end
                    if (w_long) begin
                        r_flag <= 1'b1;
                    end
                end
            end

            assign o_cal_flags[s] = r_flag;
        end else begin : g_off
            assign o_cal_flags[s] = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/button_debounce_long_press.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press: timestamp debouncer with long-press detect
// One debounce lane per button, a merge stage for long-press flags and the
// result register.
//
//   channel    dir   word layout (LSB first)
//   i_scan     in    raw_buttons[NUM_BUTTONS], now_ms[TIME_BITS]
//   o_result   out   stable_levels[NUM_BUTTONS], stable_prev_levels[NUM_BUTTONS],
//                    calibrate_current, calibrate_voltage
//   i_cfg      in    index 0 debounce_ms, index 1 long_press_ms
//
// One scan per clock while i_scan.ready is high; its result word is valid once the
// merge stage has loaded it. Lane stage updates debounce state, merge stage does
// the press-time compare and loads the result register.
// Stalls on o_result hold the pipe; i_scan.ready drops only when both stages
// are full. i_cfg is always ready. Reset clears the valid bits and calibrate flags
// but not the result register; registers return to 50 ms and 5000 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press #(
    parameter int unsigned NUM_BUTTONS = 4,
    parameter int unsigned TIME_BITS   = 32
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    bdl_stream_if.sink      i_scan,
    bdl_stream_if.source    o_result,
    bdl_cfg_if.sink         i_cfg
);
    import bdl_pkg::*;

    localparam int unsigned NOW_LSB = NUM_BUTTONS;
    localparam int unsigned CAL_LSB = 2 * NUM_BUTTONS;

    logic [DEBOUNCE_W-1:0]   r_debounce_ms;
    logic [LONG_PRESS_W-1:0] r_long_press_ms;

    logic                    r_s1_vld;
    logic [TIME_BITS-1:0]    r_now;
    logic                    r_out_vld;

    logic                    w_out_free;
    logic                    w_advance;
    logic                    w_scan_take;

    logic [NUM_BUTTONS-1:0]  w_levels;
    logic [NUM_BUTTONS-1:0]  w_prevs;
    logic [NUM_BUTTONS-1:0]  w_res_levels;
    logic [NUM_BUTTONS-1:0]  w_res_prevs;
    logic [NUM_CAL-1:0]      w_cal_flags;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= DEBOUNCE_RESET;
            r_long_press_ms <= LONG_PRESS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DEBOUNCE:   r_debounce_ms   <= i_cfg.data[DEBOUNCE_W-1:0];
                CFG_LONG_PRESS: r_long_press_ms <= i_cfg.data[LONG_PRESS_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    assign w_out_free   = !r_out_vld || o_result.ready;
    assign w_advance    = r_s1_vld && w_out_free;
    assign i_scan.ready = !r_s1_vld || w_out_free;
    assign w_scan_take  = i_scan.valid && i_scan.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_scan.ready) begin
                r_s1_vld <= i_scan.valid;
            end
            if (w_out_free) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan_take) begin
            r_now <= i_scan.data[NOW_LSB +: TIME_BITS];
        end
    end

    // one debounce lane per button
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        bdl_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (w_scan_take),
            .i_raw         (i_scan.data[b]),
            .i_now         (i_scan.data[NOW_LSB +: TIME_BITS]),
            .i_debounce_ms (r_debounce_ms),
            .o_level       (w_levels[b]),
            .o_prev        (w_prevs[b])
        );
    end

    bdl_merge #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .TIME_BITS   (TIME_BITS)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (w_advance),
        .i_now           (r_now),
        .i_levels        (w_levels),
        .i_prevs         (w_prevs),
        .i_long_press_ms (r_long_press_ms),
        .o_levels        (w_res_levels),
        .o_prevs         (w_res_prevs),
        .o_cal_flags     (w_cal_flags)
    );

    assign o_result.valid = r_out_vld;
    assign o_result.data[NUM_BUTTONS-1:0]       = w_res_levels;
    assign o_result.data[NOW_LSB +: NUM_BUTTONS] = w_res_prevs;
    assign o_result.data[CAL_LSB +: NUM_CAL]     = w_cal_flags;

endmodule

`default_nettype wire

// ===== tb/sv/button_debounce_long_press_test.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press_test: self-checking bench for the debouncer
// Scans and register writes come from one queue. A negedge driver feeds them
// to the block, and a posedge monitor predicts each accepted scan and checks
// each result word against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bdl_pkg::*;

    localparam int unsigned NBTN     = 4;
    localparam int unsigned SCAN_W   = NBTN + 32;
    localparam int unsigned RESULT_W = 2 * NBTN + 2;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    localparam int unsigned LONG_HOLD_AT     = 400;
    localparam int unsigned LONG_HOLD_CYCLES = 300;

    typedef enum logic [1:0] {STEP_SCAN, STEP_CFG, STEP_DRAIN} t_step_kind;

    typedef struct {
        t_step_kind            kind;
        logic [NBTN-1:0]       raw;
        logic [31:0]           now;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_stim_step;

    typedef struct packed {
        logic            cal_voltage;
        logic            cal_current;
        logic [NBTN-1:0] prev_levels;
        logic [NBTN-1:0] levels;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    bdl_stream_if #(.WIDTH(SCAN_W))   scan_if ();
    bdl_stream_if #(.WIDTH(RESULT_W)) res_if ();
    bdl_cfg_if                        cfg_if ();

    button_debounce_long_press u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scan   (scan_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // ------------------------------------------------------------------
    // predicted debouncer state
    // ------------------------------------------------------------------
    logic [DEBOUNCE_W-1:0]   debounce_lim;
    logic [LONG_PRESS_W-1:0] hold_lim;
    logic                    raw_seen  [NBTN];
    logic [31:0]             change_ms [NBTN];
    logic                    db_level  [NBTN];
    logic                    db_prev   [NBTN];
    logic [31:0]             press_ms  [NUM_CAL];
    logic                    cal_flag  [NUM_CAL];

    t_result     expected_results [$];
    t_stim_step  stim_q [$];

    int unsigned mismatches = 0;
    int unsigned scans_taken = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes = 0;
    logic        seen_current = 1'b0;
    logic        seen_voltage = 1'b0;

    // handshake notes from the posedge monitor to the negedge drivers
    logic        scan_taken = 1'b0;
    logic        cfg_taken = 1'b0;
    logic        res_taken = 1'b0;

    function automatic void reset_predictor();
        debounce_lim = DEBOUNCE_RESET;
        hold_lim     = LONG_PRESS_RESET;
        for (int i = 0; i < NBTN; i++) begin
            raw_seen[i]  = 1'b1;
            change_ms[i] = '0;
            db_level[i]  = 1'b0;
            db_prev[i]   = 1'b0;
        end
        for (int s = 0; s < NUM_CAL; s++) begin
            press_ms[s] = '0;
            cal_flag[s] = 1'b0;
        end
    endfunction

    function automatic t_result debounce_scan(logic [NBTN-1:0] raw, logic [31:0] now);
        t_result     r;
        logic [31:0] elapsed;
        int unsigned btn;
        for (int i = 0; i < NBTN; i++) begin
            if (raw[i] != raw_seen[i])
                change_ms[i] = now;
            elapsed = now - change_ms[i];
            if (elapsed > {16'd0, debounce_lim}) begin
                db_prev[i]  = db_level[i];
                db_level[i] = raw[i];
            end
            raw_seen[i] = raw[i];
        end
        for (int s = 0; s < NUM_CAL; s++) begin
            btn = (s == 0) ? CAL_CURRENT_BTN : CAL_VOLTAGE_BTN;
            if (db_prev[btn] && !db_level[btn])
                press_ms[s] = now;
            elapsed = now - press_ms[s];
            if (!db_level[btn] && elapsed > hold_lim)
                cal_flag[s] = 1'b1;
        end
        for (int i = 0; i < NBTN; i++) begin
            r.levels[i]      = db_level[i];
            r.prev_levels[i] = db_prev[i];
        end
        r.cal_current = cal_flag[0];
        r.cal_voltage = cal_flag[1];
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    logic [31:0]     sim_ms = '0;
    logic [NBTN-1:0] held_raw = '1;
    int unsigned     bounce_left = 0;

    function automatic void push_scan(logic [NBTN-1:0] raw, logic [31:0] now);
        t_stim_step st;
        st.kind = STEP_SCAN;
        st.raw = raw;
        st.now = now;
        st.index = '0;
        st.value = '0;
        stim_q.push_back(st);
    endfunction

    function automatic void push_cfg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        t_stim_step st;
        st.kind = STEP_CFG;
        st.raw = '0;
        st.now = '0;
        st.index = index;
        st.value = value;
        stim_q.push_back(st);
    endfunction

    function automatic void push_drain();
        t_stim_step st;
        st.kind = STEP_DRAIN;
        st.raw = '0;
        st.now = '0;
        st.index = '0;
        st.value = '0;
        stim_q.push_back(st);
    endfunction

    // mostly button presses with contact bounce, some noise and time jumps
    function automatic void gen_scans(int count, int unsigned deb, int unsigned hold);
        int unsigned     pick;
        int unsigned     step;
        int unsigned     hold_span;
        logic [NBTN-1:0] raw;
        hold_span = (hold > 32'h3FFF_FFFF) ? 32'hFFFF_FFFF : hold + hold / 4 + 1;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if (bounce_left == 0 && $urandom_range(0, 9) == 0) begin
                    held_raw = NBTN'($urandom_range(0, 15));
                    bounce_left = $urandom_range(0, 4);
                end
                if (bounce_left > 0) begin
                    raw = held_raw ^ NBTN'($urandom_range(1, 15));
                    bounce_left--;
                    step = $urandom_range(1, deb / 2 + 2);
                end else begin
                    raw = held_raw;
                    if ($urandom_range(0, 9) == 0)
                        step = $urandom_range(0, hold_span);
                    else
                        step = $urandom_range(1, deb + deb / 2 + 10);
                end
            end else if (pick < 90) begin
                raw = NBTN'($urandom_range(0, 15));
                step = $urandom_range(0, deb + 10);
            end else begin
                raw = held_raw;
                step = $urandom;
            end
            sim_ms += step;
            push_scan(raw, sim_ms);
        end
    endfunction

    // ------------------------------------------------------------------
    // clock, reset, stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned deb;
        int unsigned hold;

        i_rst_n = 1'b0;
        reset_predictor();

        // button 2 held from reset: flag rises with no press seen
        push_scan(4'hB, 32'd0);
        push_scan(4'hB, 32'd30);
        push_scan(4'hB, 32'd51);
        push_scan(4'hB, 32'd80);
        // press button 3 with one bounce, falling edge shows once
        push_scan(4'h3, 32'd100);
        push_scan(4'hB, 32'd120);
        push_scan(4'h3, 32'd130);
        push_scan(4'h3, 32'd181);
        push_scan(4'h3, 32'd200);
        // longest hold time can never be exceeded
        push_cfg(CFG_LONG_PRESS, 32'hFFFF_FFFF);
        push_scan(4'h3, 32'h8000_0000);
        push_scan(4'h3, 32'hFFFF_FFFF);
        push_cfg(CFG_LONG_PRESS, CFG_DATA_W'(LONG_PRESS_RESET));
        push_scan(4'h3, 32'd5180);
        push_scan(4'h3, 32'd5182);
        push_scan(4'hF, 32'd5300);
        push_scan(4'hF, 32'd5351);
        // debounce across timestamp wrap
        push_scan(4'h0, 32'hFFFF_FFF0);
        push_scan(4'h0, 32'h0000_0020);
        push_scan(4'h0, 32'h0000_0022);
        push_scan(4'h0, 32'h0000_0023);
        // zero debounce; writes to unused indexes must not land anywhere
        push_cfg(CFG_DEBOUNCE, 32'd0);
        push_cfg(CFG_SPARE_A, 32'd0);
        push_cfg(CFG_SPARE_B, 32'hFFFF_FFFF);
        push_scan(4'h5, 32'h0000_0023);
        push_scan(4'h5, 32'h0000_0024);
        push_scan(4'hA, 32'h0000_0024);
        push_scan(4'hA, 32'h0000_0025);
        sim_ms = 32'h0000_0025;

        // upper data bits of the debounce write are dropped
        push_cfg(CFG_DEBOUNCE, {16'hBEEF, 16'd50});
        push_cfg(CFG_LONG_PRESS, 32'd3000);
        gen_scans(145, 50, 3000);

        push_cfg(CFG_DEBOUNCE, 32'd0);
        push_cfg(CFG_LONG_PRESS, 32'd0);
        gen_scans(145, 0, 0);

        push_cfg(CFG_DEBOUNCE, 32'hFFFF_FFFF);
        push_cfg(CFG_LONG_PRESS, 32'hFFFF_FFFF);
        gen_scans(145, 65535, 32'hFFFF_FFFF);

        sim_ms = 32'hFFFF_F000;
        deb = $urandom_range(1, 300);
        hold = $urandom_range(100, 20000);
        push_cfg(CFG_DEBOUNCE, deb);
        push_cfg(CFG_LONG_PRESS, hold);
        gen_scans(145, deb, hold);

        deb = $urandom_range(0, 65535);
        hold = $urandom_range(0, 40000);
        push_cfg(CFG_DEBOUNCE, {16'($urandom), 16'(deb)});
        push_cfg(CFG_SPARE_A, $urandom);
        push_cfg(CFG_LONG_PRESS, hold);
        gen_scans(70, deb, hold);
        push_drain();
        gen_scans(75, deb, hold);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || scan_if.valid || cfg_if.valid ||
               expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d result words from %0d scans, %0d register writes issued.",
                 results_checked, scans_taken, cfg_writes);
        $display("Calibrate flags seen set: current %0b, voltage %0b.",
                 seen_current, seen_voltage);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: scans and register writes, changed at the falling edge
    // ------------------------------------------------------------------
    int unsigned scan_gap = 0;
    logic        src_burst = 1'b0;

    always @(negedge i_clk) begin
        t_stim_step st;
        logic       scan_v;
        logic       cfg_v;
        if (!i_rst_n) begin
            scan_if.valid <= 1'b0;
            scan_if.data  <= '0;
            cfg_if.valid  <= 1'b0;
            cfg_if.index  <= '0;
            cfg_if.data   <= '0;
        end else begin
            scan_v = scan_if.valid;
            cfg_v  = cfg_if.valid;
            if (scan_taken) begin
                scan_taken = 1'b0;
                scan_v = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    src_burst = !src_burst;
                scan_gap = src_burst ? 0 : $urandom_range(0, 19);
            end
            if (cfg_taken) begin
                cfg_taken = 1'b0;
                cfg_v = 1'b0;
            end
            if (!scan_v && !cfg_v && stim_q.size() != 0) begin
                case (stim_q[0].kind)
                    STEP_SCAN: begin
                        if (scan_gap > 0) begin
                            scan_gap--;
                        end else begin
                            st = stim_q.pop_front();
                            scan_v = 1'b1;
                            scan_if.data <= {st.now, st.raw};
                        end
                    end
                    // registers change only with nothing in flight
                    STEP_CFG: begin
                        if (expected_results.size() == 0) begin
                            st = stim_q.pop_front();
                            cfg_v = 1'b1;
                            cfg_if.index <= st.index;
                            cfg_if.data  <= st.value;
                        end
                    end
                    STEP_DRAIN: begin
                        if (expected_results.size() == 0)
                            void'(stim_q.pop_front());
                    end
                    default: ;
                endcase
            end
            scan_if.valid <= scan_v;
            cfg_if.valid  <= cfg_v;
        end
    end

    // ------------------------------------------------------------------
    // result sink: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    int unsigned res_stall = 0;
    int unsigned hold_left = 0;
    logic        long_hold_done = 1'b0;
    logic        sink_burst = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_taken) begin
                res_taken = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    sink_burst = !sink_burst;
                res_stall = sink_burst ? 0 : $urandom_range(0, 19);
            end
            if (!long_hold_done && results_checked >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (res_stall > 0) begin
                res_stall--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: check results, then record accepted scans and writes
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                res_taken = 1'b1;
                results_checked++;
                seen_current |= got.cal_current;
                seen_voltage |= got.cal_voltage;
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result word %0h with no scan pending", $time, got);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("stable_levels", want.levels, got.levels);
                    check_field("stable_prev_levels", want.prev_levels, got.prev_levels);
                    check_field("calibrate_current", want.cal_current, got.cal_current);
                    check_field("calibrate_voltage", want.cal_voltage, got.cal_voltage);
                end
            end
            if (scan_if.valid && scan_if.ready) begin
                expected_results.push_back(debounce_scan(scan_if.data[NBTN-1:0],
                                                         scan_if.data[SCAN_W-1:NBTN]));
                scan_taken = 1'b1;
                scans_taken++;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_DEBOUNCE:   debounce_lim = cfg_if.data[DEBOUNCE_W-1:0];
                    CFG_LONG_PRESS: hold_lim = cfg_if.data[LONG_PRESS_W-1:0];
                    default: ;
                endcase
                cfg_taken = 1'b1;
                cfg_writes++;
            end
        end
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/bdl_pkg.sv
sv/bdl_if.sv
sv/bdl_lane.sv
sv/bdl_merge.sv
sv/button_debounce_long_press.sv
tb/sv/button_debounce_long_press_test.sv
